### sv/gdr_pkg.sv
// ----------------------------------------------------------------------------
// gdr_pkg
// shared constants, bus widths and sequencer states of the grid ray caster
// ----------------------------------------------------------------------------
package gdr_pkg;

   localparam int MapDim   = 64;
   localparam int CoordW   = 6;
   localparam int AddrW    = 2 * CoordW;
   localparam int Depth    = MapDim * MapDim;
   localparam int CellW    = 8;
   localparam int Frac     = 16;

   localparam int DivW     = 39;          // dividend and quotient
   localparam int DvsW     = 41;          // divisor
   localparam int MulAW    = 39;
   localparam int MulBW    = 19;
   localparam int ProdW    = MulAW + MulBW;
   localparam int AccW     = 63;          // crossing accumulators, q.2f
   localparam int DqW      = 33;
   localparam int MapW     = 9;           // signed map coordinate during the walk
   localparam int StepCntW = 8;

   localparam logic [AccW-1:0]     CrossSat  = AccW'(64'h4000_0000_0000_0000);
   localparam logic [23:0]         DistSat   = 24'hFF_FFFF;
   localparam logic [StepCntW-1:0] StepLimit = StepCntW'(2 * MapDim + 4);

   localparam int ReqW = 120;
   localparam int RspW = 104;

   localparam logic [1:0] CsrMapWidth   = 2'd0;
   localparam logic [1:0] CsrMapHeight  = 2'd1;
   localparam logic [1:0] CsrViewHeight = 2'd2;

   localparam logic [1:0] FaceEast  = 2'd0;
   localparam logic [1:0] FaceSouth = 2'd1;
   localparam logic [1:0] FaceWest  = 2'd2;
   localparam logic [1:0] FaceNorth = 2'd3;

   localparam logic KindWrite = 1'b0;
   localparam logic KindCast  = 1'b1;

   typedef enum logic [3:0] {
      StClear, StIdle, StXDiv, StXMul, StYDiv, StYMul, StStep, StTest,
      StDDiv, StOMul, StRMul, StHDiv, StFinish
   } state_type;

endpackage

### sv/gdr_ram.sv
// ----------------------------------------------------------------------------
// gdr_ram
// generic single-clock ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module gdr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/gdr_div.sv
// ----------------------------------------------------------------------------
// gdr_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module gdr_div (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [gdr_pkg::DivW-1:0] dividend,
   input  logic [gdr_pkg::DvsW-1:0] divisor,
   output logic                     done,
   output logic [gdr_pkg::DivW-1:0] quotient
);

   localparam int CntW = $clog2(gdr_pkg::DivW + 1);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [CntW-1:0]          cnt_ff, cnt_in;
   logic [gdr_pkg::DvsW-1:0] rem_ff, rem_in;
   logic [gdr_pkg::DvsW-1:0] dvs_ff, dvs_in;
   logic [gdr_pkg::DivW-1:0] quo_ff, quo_in;
   logic [gdr_pkg::DvsW:0]   shifted;
   logic [gdr_pkg::DvsW:0]   diff;
   logic                     ge;

   always_comb begin
      shifted = {rem_ff, quo_ff[gdr_pkg::DivW-1]};
      diff    = shifted - {1'b0, dvs_ff};
      ge      = shifted >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CntW'(gdr_pkg::DivW);
         rem_in  = '0;
         dvs_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = ge ? diff[gdr_pkg::DvsW-1:0] : shifted[gdr_pkg::DvsW-1:0];
         quo_in = {quo_ff[gdr_pkg::DivW-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### sv/gdr_mul.sv
// ----------------------------------------------------------------------------
// gdr_mul
// shift-and-add unsigned multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module gdr_mul (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [gdr_pkg::MulAW-1:0] op_a,
   input  logic [gdr_pkg::MulBW-1:0] op_b,
   output logic                      done,
   output logic [gdr_pkg::ProdW-1:0] product
);

   localparam int CntW = $clog2(gdr_pkg::MulBW + 1);

   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [CntW-1:0]           cnt_ff, cnt_in;
   logic [gdr_pkg::ProdW-1:0] a_ff, a_in;
   logic [gdr_pkg::MulBW-1:0] b_ff, b_in;
   logic [gdr_pkg::ProdW-1:0] acc_ff, acc_in;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CntW'(gdr_pkg::MulBW);
         a_in    = gdr_pkg::ProdW'(op_a);
         b_in    = op_b;
         acc_in  = '0;
      end else if (busy_ff) begin
         if (b_ff[0]) begin
            acc_in = acc_ff + a_ff;
         end
         a_in   = {a_ff[gdr_pkg::ProdW-2:0], 1'b0};
         b_in   = {1'b0, b_ff[gdr_pkg::MulBW-1:1]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

### sv/grid_dda_raycaster.sv
// ----------------------------------------------------------------------------
// grid_dda_raycaster
// tile map in block ram, dda walk with one map read per cell, serial units
// for the step, distance and projection arithmetic
// a cell write goes to the map in the cycle it is accepted; a ray runs up to
//   four divides and four multiplies on a shared divider and multiplier,
//   with one map read per step
// throughput: one ray at a time; the next item is taken while a result waits
// reset: clearing pass over all 4096 map cells, no items taken until it ends
// ----------------------------------------------------------------------------
module grid_dda_raycaster (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // cell_x, cell_y, cell_value, pos_x, pos_y, dir_x, dir_y, view_cos, pad
   input  logic [gdr_pkg::ReqW-1:0] req_tdata,
   // kind
   input  logic                     req_tuser,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // distance, face, wall_offset, column_height, sky_row, floor_row,
   // hit_cell_x, hit_cell_y, pad
   output logic [gdr_pkg::RspW-1:0] rsp_tdata,
   input  logic                     csr_wr_en,
   input  logic [1:0]               csr_index,
   input  logic [11:0]              csr_wdata
);

   gdr_pkg::state_type state_ff, state_in;
   logic kick_ff;

   logic [6:0]  map_w_ff, map_h_ff;
   logic [11:0] view_h_ff;
   logic [gdr_pkg::AddrW-1:0] clr_ff, clr_in;

   logic [21:0] px_ff, py_ff, px_in, py_in;
   logic signed [18:0] dx_ff, dy_ff, dx_in, dy_in;
   logic [16:0] vc_ff, vc_in;
   logic signed [gdr_pkg::MapW-1:0] mx_ff, my_ff, mx_in, my_in;
   logic [gdr_pkg::StepCntW-1:0] n_ff, n_in;
   logic [gdr_pkg::AccW-1:0] cx_ff, cy_ff, cx_in, cy_in;
   logic [gdr_pkg::DqW-1:0]  dqx_ff, dqy_ff, dqx_in, dqy_in;
   logic axis_ff, axis_in;
   logic [gdr_pkg::DivW-1:0] dist_ff, dist_in;
   logic [15:0] woff_ff, woff_in, hgt_ff, hgt_in;
   logic [gdr_pkg::DvsW-1:0] real_ff, real_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [gdr_pkg::RspW-1:0] rsp_data_ff, rsp_data_in;

   logic accept, rsp_load;
   logic [18:0] magx, magy, mface, magod;
   logic [16:0] partx, party;
   logic [6:0]  w_eff, h_eff;
   logic take_x, inb;
   logic [gdr_pkg::AccW-1:0] csum;
   logic signed [gdr_pkg::MapW-1:0] mx_nx, my_nx;
   logic signed [25:0] bnd, diffv;
   logic [25:0] numv;
   logic [21:0] opos;
   logic neg_face, od_neg;
   logic [15:0] offv;
   logic [1:0]  face_code;
   logic [16:0] vsum;
   logic [11:0] frow, srow;
   logic [23:0] dist_out;

   logic div_start, div_done, mul_start, mul_done;
   logic [gdr_pkg::DivW-1:0]  div_dividend, div_quo;
   logic [gdr_pkg::DvsW-1:0]  div_divisor;
   logic [gdr_pkg::MulAW-1:0] mul_a;
   logic [gdr_pkg::MulBW-1:0] mul_b;
   logic [gdr_pkg::ProdW-1:0] mul_prod;

   logic ram_we, ram_re;
   logic [gdr_pkg::AddrW-1:0] ram_waddr, ram_raddr;
   logic [gdr_pkg::CellW-1:0] ram_wdata, ram_rdata;

   assign req_tready = (state_ff == gdr_pkg::StIdle);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // operand shaping
   always_comb begin
      magx  = dx_ff[18] ? 19'(-dx_ff) : 19'(dx_ff);
      magy  = dy_ff[18] ? 19'(-dy_ff) : 19'(dy_ff);
      partx = dx_ff[18] ? {1'b0, px_ff[15:0]} : 17'h1_0000 - {1'b0, px_ff[15:0]};
      party = dy_ff[18] ? {1'b0, py_ff[15:0]} : 17'h1_0000 - {1'b0, py_ff[15:0]};
      w_eff = (map_w_ff > 7'(gdr_pkg::MapDim)) ? 7'(gdr_pkg::MapDim) : map_w_ff;
      h_eff = (map_h_ff > 7'(gdr_pkg::MapDim)) ? 7'(gdr_pkg::MapDim) : map_h_ff;

      take_x = cx_ff < cy_ff;
      csum   = take_x ? cx_ff + {14'b0, dqx_ff, 16'b0} : cy_ff + {14'b0, dqy_ff, 16'b0};
      mx_nx  = mx_ff;
      my_nx  = my_ff;
      if (take_x) begin
         mx_nx = dx_ff[18] ? mx_ff - 9'sd1 : mx_ff + 9'sd1;
      end else begin
         my_nx = dy_ff[18] ? my_ff - 9'sd1 : my_ff + 9'sd1;
      end
      inb = !mx_nx[gdr_pkg::MapW-1] && !my_nx[gdr_pkg::MapW-1]
            && (mx_nx < $signed({2'b0, w_eff})) && (my_nx < $signed({2'b0, h_eff}));

      mface    = axis_ff ? magy : magx;
      magod    = axis_ff ? magx : magy;
      neg_face = axis_ff ? dy_ff[18] : dx_ff[18];
      od_neg   = axis_ff ? dx_ff[18] : dy_ff[18];
      opos     = axis_ff ? px_ff : py_ff;
      bnd      = $signed({axis_ff ? my_ff : mx_ff, 16'b0}) + (neg_face ? 26'sh1_0000 : 26'sd0);
      diffv    = bnd - $signed({4'b0, axis_ff ? py_ff : px_ff});
      numv     = diffv[25] ? 26'(-diffv) : 26'(diffv);
      offv     = mul_prod[31:16];

      face_code = axis_ff ? (dy_ff[18] ? gdr_pkg::FaceNorth : gdr_pkg::FaceSouth)
                          : (dx_ff[18] ? gdr_pkg::FaceWest : gdr_pkg::FaceEast);
      vsum = {5'b0, view_h_ff} + {1'b0, hgt_ff};
      if (view_h_ff == 12'd0) begin
         frow = 12'd0;
      end else if (vsum[16:1] >= {4'b0, view_h_ff}) begin
         frow = view_h_ff - 12'd1;
      end else begin
         frow = vsum[12:1];
      end
      srow     = ({4'b0, view_h_ff} > hgt_ff) ? 12'(({4'b0, view_h_ff} - hgt_ff) >> 1) : 12'd0;
      dist_out = (|dist_ff[gdr_pkg::DivW-1:24]) ? gdr_pkg::DistSat : dist_ff[23:0];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gdr_pkg::StClear:  if (clr_ff == '1) state_in = gdr_pkg::StIdle;
         gdr_pkg::StIdle:   if (accept && req_tuser == gdr_pkg::KindCast)
                               state_in = gdr_pkg::StXDiv;
         gdr_pkg::StXDiv:   if (magx == 19'd0) state_in = gdr_pkg::StYDiv;
                            else if (div_done) state_in = gdr_pkg::StXMul;
         gdr_pkg::StXMul:   if (mul_done) state_in = gdr_pkg::StYDiv;
         gdr_pkg::StYDiv:   if (magy == 19'd0) state_in = gdr_pkg::StStep;
                            else if (div_done) state_in = gdr_pkg::StYMul;
         gdr_pkg::StYMul:   if (mul_done) state_in = gdr_pkg::StStep;
         gdr_pkg::StStep:   state_in = inb ? gdr_pkg::StTest : gdr_pkg::StDDiv;
         gdr_pkg::StTest:   if (ram_rdata != '0 || n_ff == gdr_pkg::StepLimit)
                               state_in = gdr_pkg::StDDiv;
                            else state_in = gdr_pkg::StStep;
         gdr_pkg::StDDiv:   if (mface == 19'd0) state_in = gdr_pkg::StRMul;
                            else if (div_done) state_in = gdr_pkg::StOMul;
         gdr_pkg::StOMul:   if (mul_done) state_in = gdr_pkg::StRMul;
         gdr_pkg::StRMul:   if (mul_done) state_in = gdr_pkg::StHDiv;
         gdr_pkg::StHDiv:   if (div_done) state_in = gdr_pkg::StFinish;
         gdr_pkg::StFinish: if (rsp_load) state_in = gdr_pkg::StIdle;
         default:           state_in = gdr_pkg::StIdle;
      endcase
   end

   // outputs and datapath
   always_comb begin
      clr_in  = clr_ff;
      px_in   = px_ff;
      py_in   = py_ff;
      dx_in   = dx_ff;
      dy_in   = dy_ff;
      vc_in   = vc_ff;
      mx_in   = mx_ff;
      my_in   = my_ff;
      n_in    = n_ff;
      cx_in   = cx_ff;
      cy_in   = cy_ff;
      dqx_in  = dqx_ff;
      dqy_in  = dqy_ff;
      axis_in = axis_ff;
      dist_in = dist_ff;
      woff_in = woff_ff;
      real_in = real_ff;
      hgt_in  = hgt_ff;

      ram_we    = 1'b0;
      ram_waddr = clr_ff;
      ram_wdata = '0;
      ram_re    = 1'b0;
      ram_raddr = {my_nx[gdr_pkg::CoordW-1:0], mx_nx[gdr_pkg::CoordW-1:0]};

      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;
      mul_start    = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      rsp_load     = 1'b0;

      case (state_ff)
         gdr_pkg::StClear: begin
            ram_we = 1'b1;
            clr_in = clr_ff + 1'b1;
         end
         gdr_pkg::StIdle: begin
            if (accept && req_tuser == gdr_pkg::KindWrite) begin
               ram_we    = 1'b1;
               ram_waddr = {req_tdata[11:6], req_tdata[5:0]};
               ram_wdata = req_tdata[19:12];
            end
            px_in = req_tdata[41:20];
            py_in = req_tdata[63:42];
            dx_in = $signed(req_tdata[82:64]);
            dy_in = $signed(req_tdata[101:83]);
            vc_in = req_tdata[118:102];
            mx_in = $signed({3'b0, req_tdata[41:36]});
            my_in = $signed({3'b0, req_tdata[63:58]});
            n_in  = '0;
         end
         gdr_pkg::StXDiv: begin
            div_start    = kick_ff && magx != 19'd0;
            div_dividend = gdr_pkg::DivW'(64'h1_0000_0000);
            div_divisor  = gdr_pkg::DvsW'(magx);
            if (magx == 19'd0) begin
               cx_in  = gdr_pkg::CrossSat;
               dqx_in = '0;
            end else if (div_done) begin
               dqx_in = div_quo[gdr_pkg::DqW-1:0];
            end
         end
         gdr_pkg::StXMul: begin
            mul_start = kick_ff;
            mul_a     = gdr_pkg::MulAW'(dqx_ff);
            mul_b     = gdr_pkg::MulBW'(partx);
            if (mul_done) cx_in = gdr_pkg::AccW'(mul_prod);
         end
         gdr_pkg::StYDiv: begin
            div_start    = kick_ff && magy != 19'd0;
            div_dividend = gdr_pkg::DivW'(64'h1_0000_0000);
            div_divisor  = gdr_pkg::DvsW'(magy);
            if (magy == 19'd0) begin
               cy_in  = gdr_pkg::CrossSat;
               dqy_in = '0;
            end else if (div_done) begin
               dqy_in = div_quo[gdr_pkg::DqW-1:0];
            end
         end
         gdr_pkg::StYMul: begin
            mul_start = kick_ff;
            mul_a     = gdr_pkg::MulAW'(dqy_ff);
            mul_b     = gdr_pkg::MulBW'(party);
            if (mul_done) cy_in = gdr_pkg::AccW'(mul_prod);
         end
         gdr_pkg::StStep: begin
            if (take_x) begin
               cx_in   = (csum > gdr_pkg::CrossSat) ? gdr_pkg::CrossSat : csum;
               axis_in = 1'b0;
            end else begin
               cy_in   = (csum > gdr_pkg::CrossSat) ? gdr_pkg::CrossSat : csum;
               axis_in = 1'b1;
            end
            mx_in  = mx_nx;
            my_in  = my_nx;
            n_in   = n_ff + 1'b1;
            ram_re = inb;
         end
         gdr_pkg::StDDiv: begin
            div_start    = kick_ff && mface != 19'd0;
            div_dividend = {numv[22:0], 16'b0};
            div_divisor  = gdr_pkg::DvsW'(mface);
            if (mface == 19'd0) begin
               dist_in = gdr_pkg::DivW'(gdr_pkg::DistSat);
               woff_in = '0;
            end else if (div_done) begin
               dist_in = div_quo;
            end
         end
         gdr_pkg::StOMul: begin
            mul_start = kick_ff;
            mul_a     = dist_ff;
            mul_b     = magod;
            if (mul_done) woff_in = od_neg ? opos[15:0] - offv : opos[15:0] + offv;
         end
         gdr_pkg::StRMul: begin
            mul_start = kick_ff;
            mul_a     = dist_ff;
            mul_b     = gdr_pkg::MulBW'(vc_ff);
            if (mul_done) begin
               real_in = (mul_prod[56:16] == '0) ? gdr_pkg::DvsW'(1) : mul_prod[56:16];
            end
         end
         gdr_pkg::StHDiv: begin
            div_start    = kick_ff;
            div_dividend = gdr_pkg::DivW'({view_h_ff, 16'b0});
            div_divisor  = real_ff;
            if (div_done) hgt_in = (|div_quo[gdr_pkg::DivW-1:16]) ? 16'hFFFF : div_quo[15:0];
         end
         gdr_pkg::StFinish: begin
            rsp_load = !rsp_valid_ff || rsp_tready;
         end
         default: begin
         end
      endcase

      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);
      rsp_data_in  = rsp_load
         ? {6'b0, my_ff[7:0], mx_ff[7:0], frow, srow, hgt_ff, woff_ff, face_code, dist_out}
         : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gdr_pkg::StClear;
         kick_ff      <= 1'b0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         map_w_ff     <= 7'd64;
         map_h_ff     <= 7'd64;
         view_h_ff    <= 12'd480;
      end else begin
         state_ff     <= state_in;
         kick_ff      <= (state_in != state_ff);
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            case (csr_index)
               gdr_pkg::CsrMapWidth:   map_w_ff  <= csr_wdata[6:0];
               gdr_pkg::CsrMapHeight:  map_h_ff  <= csr_wdata[6:0];
               gdr_pkg::CsrViewHeight: view_h_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
      px_ff       <= px_in;
      py_ff       <= py_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      vc_ff       <= vc_in;
      mx_ff       <= mx_in;
      my_ff       <= my_in;
      n_ff        <= n_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      dqx_ff      <= dqx_in;
      dqy_ff      <= dqy_in;
      axis_ff     <= axis_in;
      dist_ff     <= dist_in;
      woff_ff     <= woff_in;
      real_ff     <= real_in;
      hgt_ff      <= hgt_in;
      rsp_data_ff <= rsp_data_in;
   end

   gdr_ram #(
      .WIDTH (gdr_pkg::CellW),
      .DEPTH (gdr_pkg::Depth)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   gdr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   gdr_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .done    (mul_done),
      .product (mul_prod)
   );

endmodule
